>>> rtl/pnos_pkg.sv
// Shared types, constants and the gradient function for the fractal noise block.
// Depends on nothing; every other file imports it.
`default_nettype none
package pnos_pkg;

	localparam int TABLE_SIZE  = 256;
	localparam int TBL_W       = $clog2(TABLE_SIZE);
	localparam int MAX_OCTAVES = 16;
	localparam int OCT_W       = 5;
	localparam int ONE_Q16     = 65536;
	localparam int PX_W        = 32 + TBL_W;
	localparam int WGT_W       = 17 + $clog2(MAX_OCTAVES);
	localparam int SUM_W       = 41;
	localparam int QUO_W       = SUM_W - 1;
	localparam int OUT_MAX     = 131071;
	localparam int OUT_MIN     = -131072;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	typedef logic [TBL_W-1:0] tidx_t;
	typedef logic [7:0]       hval_t;
	typedef logic signed [19:0] grad_t;

	typedef struct packed {
		logic             start;
		logic [QUO_W-1:0] num;
		logic [WGT_W-1:0] den;
	} div_req_t;

	// Improved-noise gradient: the low four hash bits pick the axes and signs.
	function automatic grad_t grad(input logic [3:0] h, input logic signed [17:0] gx,
			input logic signed [17:0] gy, input logic signed [17:0] gz);
		grad_t u;
		grad_t v;
		u = (h < 4'd8) ? 20'(gx) : 20'(gy);
		if (h < 4'd4) begin
			v = 20'(gy);
		end else if (h == 4'd12 || h == 4'd14) begin
			v = 20'(gx);
		end else begin
			v = 20'(gz);
		end
		if (h[0]) begin
			u = -u;
		end
		if (h[1]) begin
			v = -v;
		end
		return u + v;
	endfunction

endpackage
`default_nettype wire

>>> rtl/pnos_hash_ram.sv
// Hash table storage: one write port and two registered read ports.
// Depends on pnos_pkg.
`default_nettype none
module pnos_hash_ram import pnos_pkg::*; (
	input  wire         clk,
	input  wire         wr_en,
	input  tidx_t       wr_addr,
	input  hval_t       wr_data,
	input  tidx_t       rd_addr_a,
	input  tidx_t       rd_addr_b,
	output hval_t       rd_data_a,
	output hval_t       rd_data_b
);

	hval_t mem [TABLE_SIZE];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule
`default_nettype wire

>>> rtl/pnos_div.sv
// Restoring divider, one quotient bit per cycle, for the final normalization.
// Depends on pnos_pkg.
`default_nettype none
module pnos_div import pnos_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WGT_W-1:0] rem_q;
	logic [WGT_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [WGT_W:0]   trial;
	logic [WGT_W:0]   diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, quo_q[QUO_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WGT_W-1:0] : trial[WGT_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

>>> rtl/perlin_noise_octave_sum.sv
// Fractal sum of 3D gradient noise over a loadable hash table; top level.
// Depends on pnos_pkg, pnos_hash_ram and pnos_div.
// Sequence: a load word writes one table entry. An evaluate word runs, per
// octave, the three fades on the shared multiplier, the chained table reads on
// the two RAM ports, the seven lerps and the weighting, after a setup that
// scales the three coordinates; then come the division into a 40-bit quotient
// and its done flag, and the load of the output register. One word at a time.
// Reset: asynchronous, active low; the frequency register returns to 1.0, the table
// contents stay undefined until loaded.
`default_nettype none
module perlin_noise_octave_sum import pnos_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [31:0]        cfg_data,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                req_type,
	input  wire  [7:0]         entry_index,
	input  wire  [7:0]         entry_value,
	input  wire  signed [31:0] coord_x,
	input  wire  signed [31:0] coord_y,
	input  wire  signed [31:0] coord_z,
	input  wire  [4:0]         octave_count,
	input  wire  [16:0]        persistence,
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [17:0] noise_value
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_MX, ST_MY, ST_MZ, ST_PZ,
		ST_F1, ST_F2, ST_F3, ST_F4,
		ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7,
		ST_LA, ST_LB, ST_A1, ST_A2, ST_A3, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;

	// Control registers.
	logic [31:0]        base_freq_q;
	logic               out_valid_q;
	logic signed [17:0] noise_q;
	logic [OCT_W-1:0]   oct_q;
	logic [OCT_W-1:0]   octs_q;
	logic [1:0]         k_q;
	logic [3:0]         cnt_q;

	// Datapath registers.
	logic signed [31:0] x_q, y_q, z_q;
	logic [16:0]        pers_q;
	logic [PX_W-1:0]    px_q, py_q, pz_q;
	logic signed [65:0] prod_q;
	logic [20:0]        poly_q;
	logic [16:0]        fade_q [3];
	logic signed [19:0] q_q [8];
	tidx_t              b_q, aa_q, ab_q, ba_q, bb_q;
	logic [16:0]        amp_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [WGT_W-1:0]   wgt_q;
	logic signed [17:0] sat_q;

	logic               in_acc;
	logic               last_oct;
	logic signed [32:0] mul_a, mul_b;
	logic [15:0]        frac;
	logic [16:0]        lerp_t;
	logic signed [20:0] diff;
	logic signed [65:0] psh;
	logic signed [19:0] lerp_res;
	logic [36:0]        poly_full;
	tidx_t              cx, cy, cz;
	logic signed [17:0] fx, fy, fz, gx, gy, gz;
	tidx_t              rd_addr_a, rd_addr_b;
	hval_t              rd_data_a, rd_data_b;
	tidx_t              hsum_a, hsum_b;
	logic [OCT_W-1:0]   oct_clamp;
	div_req_t           div_req;
	logic               div_done;
	logic [QUO_W-1:0]   div_quo;
	logic signed [17:0] sat_val;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign noise_value = noise_q;
	assign last_oct  = (oct_q + OCT_W'(1) == octs_q);

	// Octave count zero runs one octave; counts above the maximum are clamped.
	always_comb begin
		if (octave_count == '0) begin
			oct_clamp = OCT_W'(1);
		end else if (octave_count > OCT_W'(MAX_OCTAVES)) begin
			oct_clamp = OCT_W'(MAX_OCTAVES);
		end else begin
			oct_clamp = octave_count;
		end
	end

	// Lattice cell and fraction of each axis for the current octave. The scaled
	// coordinates shift left once per octave, so the same bits are always read.
	always_comb begin
		cx = px_q[PX_W-1:32];
		cy = py_q[PX_W-1:32];
		cz = pz_q[PX_W-1:32];
		fx = {2'b00, px_q[31:16]};
		fy = {2'b00, py_q[31:16]};
		fz = {2'b00, pz_q[31:16]};
		gx = fx - 18'sd65536;
		gy = fy - 18'sd65536;
		gz = fz - 18'sd65536;
	end

	always_comb begin
		unique case (k_q)
			2'd0:    frac = px_q[31:16];
			2'd1:    frac = py_q[31:16];
			default: frac = pz_q[31:16];
		endcase
	end

	// The lerp queue count tells which fade weight applies: four lerps along x,
	// two along y, and the last one along z.
	always_comb begin
		priority if (cnt_q >= 4'd5) begin
			lerp_t = fade_q[0];
		end else if (cnt_q >= 4'd3) begin
			lerp_t = fade_q[1];
		end else begin
			lerp_t = fade_q[2];
		end
	end

	always_comb begin
		diff      = 21'(q_q[1]) - 21'(q_q[0]);
		psh       = prod_q >>> 16;
		lerp_res  = q_q[0] + psh[19:0];
		// poly = 6 t^2 - 15 t + 10 in Q32, t^2 taken from the product register.
		poly_full = (37'(prod_q[31:0]) << 2) + (37'(prod_q[31:0]) << 1)
			- (37'(frac) << 20) + (37'(frac) << 16) + (37'(10) << 32);
		hsum_a    = tidx_t'(rd_data_a);
		hsum_b    = tidx_t'(rd_data_b);
	end

	// The one shared multiplier: operands follow the sequencer state.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MX: begin
				mul_a = {1'b0, x_q};
				mul_b = {1'b0, base_freq_q};
			end
			ST_MY: begin
				mul_a = {1'b0, y_q};
				mul_b = {1'b0, base_freq_q};
			end
			ST_MZ: begin
				mul_a = {1'b0, z_q};
				mul_b = {1'b0, base_freq_q};
			end
			ST_F1: begin
				mul_a = {17'd0, frac};
				mul_b = {17'd0, frac};
			end
			ST_F2: begin
				mul_a = {17'd0, prod_q[31:16]};
				mul_b = {17'd0, frac};
			end
			ST_F3: begin
				mul_a = {17'd0, prod_q[31:16]};
				mul_b = {12'd0, poly_q};
			end
			ST_LA: begin
				mul_a = {16'd0, lerp_t};
				mul_b = 33'(diff);
			end
			ST_A1: begin
				mul_a = 33'(q_q[0]);
				mul_b = {16'd0, amp_q};
			end
			ST_A2: begin
				mul_a = {16'd0, amp_q};
				mul_b = {16'd0, pers_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Table read addresses for the chained hash lookups. Each state's address
	// pair returns data from the registered read ports in the next state.
	always_comb begin
		rd_addr_a = '0;
		rd_addr_b = '0;
		unique case (state_q)
			ST_H0: begin
				rd_addr_a = cx;
				rd_addr_b = cx + tidx_t'(1);
			end
			ST_H1: begin
				rd_addr_a = hsum_a + cy;
				rd_addr_b = hsum_a + cy + tidx_t'(1);
			end
			ST_H2: begin
				rd_addr_a = b_q;
				rd_addr_b = b_q + tidx_t'(1);
			end
			ST_H3: begin
				rd_addr_a = aa_q;
				rd_addr_b = hsum_a + cz;
			end
			ST_H4: begin
				rd_addr_a = ab_q;
				rd_addr_b = bb_q;
			end
			ST_H5: begin
				rd_addr_a = aa_q + tidx_t'(1);
				rd_addr_b = ba_q + tidx_t'(1);
			end
			ST_H6: begin
				rd_addr_a = ab_q + tidx_t'(1);
				rd_addr_b = bb_q + tidx_t'(1);
			end
			default: begin
				rd_addr_a = '0;
				rd_addr_b = '0;
			end
		endcase
	end

	// Quotient sign and saturation to signed Q2.16.
	always_comb begin
		if (sum_q[SUM_W-1]) begin
			if (div_quo > QUO_W'(-OUT_MIN)) begin
				sat_val = 18'(OUT_MIN);
			end else begin
				sat_val = -$signed(div_quo[17:0]);
			end
		end else begin
			if (div_quo > QUO_W'(OUT_MAX)) begin
				sat_val = 18'(OUT_MAX);
			end else begin
				sat_val = $signed(div_quo[17:0]);
			end
		end
	end

	always_comb begin
		div_req.start = (state_q == ST_A3) && last_oct;
		div_req.num   = sum_q[SUM_W-1] ? QUO_W'(-sum_q) : QUO_W'(sum_q);
		div_req.den   = wgt_q;
	end

	pnos_hash_ram u_ram (
		.clk       (clk),
		.wr_en     (in_acc && (req_type == REQ_LOAD)),
		.wr_addr   (tidx_t'(entry_index)),
		.wr_data   (entry_value),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	pnos_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Sequencer, configuration register and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_freq_q <= 32'd65536;
			out_valid_q <= 1'b0;
			noise_q     <= '0;
			oct_q       <= '0;
			octs_q      <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				base_freq_q <= cfg_data;
			end
			// A taken result clears valid, unless a new word is loaded in its place.
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (req_type == REQ_EVAL)) begin
						octs_q  <= oct_clamp;
						oct_q   <= '0;
						k_q     <= '0;
						state_q <= ST_MX;
					end
				end
				ST_MX: state_q <= ST_MY;
				ST_MY: state_q <= ST_MZ;
				ST_MZ: state_q <= ST_PZ;
				ST_PZ: state_q <= ST_F1;
				ST_F1: state_q <= ST_F2;
				ST_F2: state_q <= ST_F3;
				ST_F3: state_q <= ST_F4;
				ST_F4: begin
					if (k_q == 2'd2) begin
						k_q     <= '0;
						state_q <= ST_H0;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_F1;
					end
				end
				ST_H0: state_q <= ST_H1;
				ST_H1: state_q <= ST_H2;
				ST_H2: state_q <= ST_H3;
				ST_H3: state_q <= ST_H4;
				ST_H4: state_q <= ST_H5;
				ST_H5: state_q <= ST_H6;
				ST_H6: state_q <= ST_H7;
				ST_H7: begin
					cnt_q   <= 4'd8;
					state_q <= ST_LA;
				end
				ST_LA: state_q <= ST_LB;
				ST_LB: begin
					cnt_q   <= cnt_q - 4'd1;
					state_q <= (cnt_q == 4'd2) ? ST_A1 : ST_LA;
				end
				ST_A1: state_q <= ST_A2;
				ST_A2: state_q <= ST_A3;
				ST_A3: begin
					oct_q   <= oct_q + OCT_W'(1);
					state_q <= last_oct ? ST_DIV : ST_F1;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// The result waits here only while an older word is still held.
					if (!out_valid_q || !out_stall) begin
						noise_q     <= sat_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers; none of them needs a reset.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					x_q    <= coord_x;
					y_q    <= coord_y;
					z_q    <= coord_z;
					pers_q <= (persistence > 17'(ONE_Q16)) ? 17'(ONE_Q16) : persistence;
				end
			end
			ST_MX: begin
				sum_q <= '0;
				wgt_q <= '0;
				amp_q <= 17'(ONE_Q16);
			end
			// The scaled coordinate is signed times unsigned; only its low bits
			// matter, so a negative coordinate subtracts the frequency at bit 32.
			ST_MY: px_q <= prod_q[PX_W-1:0]
				- (x_q[31] ? {base_freq_q[TBL_W-1:0], 32'd0} : PX_W'(0));
			ST_MZ: py_q <= prod_q[PX_W-1:0]
				- (y_q[31] ? {base_freq_q[TBL_W-1:0], 32'd0} : PX_W'(0));
			ST_PZ: pz_q <= prod_q[PX_W-1:0]
				- (z_q[31] ? {base_freq_q[TBL_W-1:0], 32'd0} : PX_W'(0));
			ST_F2: poly_q <= poly_full[36:16];
			ST_F4: fade_q[k_q] <= prod_q[32:16];
			ST_H1: b_q <= hsum_b + cy;
			ST_H2: begin
				aa_q <= hsum_a + cz;
				ab_q <= hsum_b + cz;
			end
			ST_H3: begin
				ba_q <= hsum_a + cz;
				bb_q <= hsum_b + cz;
			end
			ST_H4: begin
				q_q[0] <= grad(rd_data_a[3:0], fx, fy, fz);
				q_q[1] <= grad(rd_data_b[3:0], gx, fy, fz);
			end
			ST_H5: begin
				q_q[2] <= grad(rd_data_a[3:0], fx, gy, fz);
				q_q[3] <= grad(rd_data_b[3:0], gx, gy, fz);
			end
			ST_H6: begin
				q_q[4] <= grad(rd_data_a[3:0], fx, fy, gz);
				q_q[5] <= grad(rd_data_b[3:0], gx, fy, gz);
			end
			ST_H7: begin
				q_q[6] <= grad(rd_data_a[3:0], fx, gy, gz);
				q_q[7] <= grad(rd_data_b[3:0], gx, gy, gz);
			end
			ST_LB: begin
				// Pop the two oldest values and append their blend at the tail.
				for (int i = 0; i < 6; i++) begin
					if (3'(i) != 3'(cnt_q - 4'd2)) begin
						q_q[i] <= q_q[i+2];
					end
				end
				q_q[3'(cnt_q - 4'd2)] <= lerp_res;
			end
			ST_A2: begin
				sum_q <= sum_q + prod_q[SUM_W-1:0];
				wgt_q <= wgt_q + WGT_W'(amp_q);
			end
			ST_A3: begin
				amp_q <= prod_q[32:16];
				px_q  <= px_q << 1;
				py_q  <= py_q << 1;
				pz_q  <= pz_q << 1;
			end
			ST_DIV: begin
				if (div_done) begin
					sat_q <= sat_val;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
